// File: rtl/vfe_pkg.sv
// Shared types, constants and the CRC-8 step function for the VPW frame encoder.
package vfe_pkg;

  localparam int DUR_W = 9;
  localparam int POS_W = 5;

  // Symbol kind codes carried on the output tuser.
  typedef enum logic [1:0] {
    SYM_SOF = 2'd0,
    SYM_BIT = 2'd1,
    SYM_EOF = 2'd2
  } sym_kind_t;

  // Positions of the pulses within one byte's run.
  localparam logic [POS_W-1:0] POS_SOF      = 5'd0;
  localparam logic [POS_W-1:0] POS_DATA0    = 5'd1;
  localparam logic [POS_W-1:0] POS_DATA_END = 5'd8;
  localparam logic [POS_W-1:0] POS_CRC0     = 5'd9;
  localparam logic [POS_W-1:0] POS_EOF      = 5'd17;

  // Pulse lengths in microseconds at normal speed.
  localparam logic [DUR_W-1:0] SOF_US   = 9'd200;
  localparam logic [DUR_W-1:0] SHORT_US = 9'd64;
  localparam logic [DUR_W-1:0] LONG_US  = 9'd128;
  localparam logic [DUR_W-1:0] EOF_US   = 9'd300;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h1D;

  // One pulse request from the frame controller to the symbol generator.
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
    logic [7:0]       crc_tx;
    logic             speed_4x;
    logic             last;
  } sym_req_t;

  // CRC-8 over one byte, MSB first.
  function automatic logic [7:0] crc_update(input logic [7:0] c, input logic [7:0] v);
    logic [7:0] acc;
    acc = c ^ v;
    for (int k = 0; k < 8; k++) begin
      if (acc[7]) begin
        acc = {acc[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        acc = {acc[6:0], 1'b0};
      end
    end
    return acc;
  endfunction

endpackage

// File: rtl/vfe_frame_ctl.sv
// Input word register, frame state, running CRC and pulse position counter.
module vfe_frame_ctl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data,
  input  logic              in_last,
  input  logic              in_speed_4x,
  output logic              req_valid,
  input  logic              req_ready,
  output vfe_pkg::sym_req_t req
);
  import vfe_pkg::*;

  logic             busy_r, busy_nxt;
  logic             in_frame_r, in_frame_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic             speed_r, speed_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       data_r, data_nxt;
  logic [7:0]       crc_tx_r, crc_tx_nxt;
  logic             last_r, last_nxt;

  logic       advance;
  logic       at_end;
  logic       accept;
  logic [7:0] crc_upd;

  assign advance  = busy_r && req_ready;
  assign at_end   = (pos_r == (last_r ? POS_EOF : POS_DATA_END));
  assign in_ready = !busy_r || (advance && at_end);
  assign accept   = in_valid && in_ready;
  assign crc_upd  = crc_update(in_frame_r ? crc_r : CRC_INIT, in_data);

  always_comb begin
    busy_nxt     = busy_r;
    in_frame_nxt = in_frame_r;
    crc_nxt      = crc_r;
    speed_nxt    = speed_r;
    pos_nxt      = pos_r;
    data_nxt     = data_r;
    crc_tx_nxt   = crc_tx_r;
    last_nxt     = last_r;
    if (accept) begin
      busy_nxt     = 1'b1;
      in_frame_nxt = !in_last;
      crc_nxt      = in_last ? CRC_INIT : crc_upd;
      crc_tx_nxt   = ~crc_upd;
      // Speed is latched only on the byte that opens a frame.
      speed_nxt    = in_frame_r ? speed_r : in_speed_4x;
      pos_nxt      = in_frame_r ? POS_DATA0 : POS_SOF;
      data_nxt     = in_data;
      last_nxt     = in_last;
    end else if (advance && at_end) begin
      busy_nxt = 1'b0;
    end else if (advance) begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      in_frame_r <= 1'b0;
      crc_r      <= CRC_INIT;
      speed_r    <= 1'b0;
      pos_r      <= POS_SOF;
    end else begin
      busy_r     <= busy_nxt;
      in_frame_r <= in_frame_nxt;
      crc_r      <= crc_nxt;
      speed_r    <= speed_nxt;
      pos_r      <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r   <= data_nxt;
    crc_tx_r <= crc_tx_nxt;
    last_r   <= last_nxt;
  end

  assign req_valid    = busy_r;
  assign req.pos      = pos_r;
  assign req.data     = data_r;
  assign req.crc_tx   = crc_tx_r;
  assign req.speed_4x = speed_r;
  assign req.last     = last_r;

endmodule

// File: rtl/vfe_symbol_gen.sv
// Pulse decode from the run position and the registered output word.
module vfe_symbol_gen (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     active_high,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  vfe_pkg::sym_req_t        req,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_pin,
  output logic [vfe_pkg::DUR_W-1:0] out_dur,
  output vfe_pkg::sym_kind_t       out_kind,
  output logic                     out_bit,
  output logic                     out_last
);
  import vfe_pkg::*;

  logic             valid_r, valid_nxt;
  logic             pin_r;
  logic [DUR_W-1:0] dur_r;
  sym_kind_t        kind_r;
  logic             bit_r;
  logic             last_r;

  logic             fire;
  logic             is_sof, is_eof, is_crc;
  logic [POS_W-1:0] pos_m1;
  logic [2:0]       idx;
  logic [7:0]       src_byte;
  logic             b;
  logic             active;
  logic             longp;
  logic [DUR_W-1:0] base_dur;
  logic             pin;
  sym_kind_t        kind;

  assign req_ready = !valid_r || out_ready;
  assign fire      = req_valid && req_ready;

  always_comb begin
    is_sof   = (req.pos == POS_SOF);
    is_eof   = (req.pos == POS_EOF);
    is_crc   = (req.pos >= POS_CRC0);
    pos_m1   = req.pos - POS_W'(1);
    idx      = pos_m1[2:0];
    src_byte = is_crc ? req.crc_tx : req.data;
    b        = src_byte[~idx];
    // The first bit after the start pulse is passive, then levels alternate.
    active   = ~req.pos[0];
    longp    = active ? ~b : b;
    if (is_sof) begin
      kind     = SYM_SOF;
      base_dur = SOF_US;
      pin      = active_high;
    end else if (is_eof) begin
      kind     = SYM_EOF;
      base_dur = EOF_US;
      pin      = ~active_high;
    end else begin
      kind     = SYM_BIT;
      base_dur = longp ? LONG_US : SHORT_US;
      pin      = active ? active_high : ~active_high;
    end
    valid_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pin_r  <= pin;
      dur_r  <= req.speed_4x ? (base_dur >> 2) : base_dur;
      kind_r <= kind;
      bit_r  <= (kind == SYM_BIT) ? b : 1'b0;
      last_r <= (req.pos == (req.last ? POS_EOF : POS_DATA_END));
    end
  end

  assign out_valid = valid_r;
  assign out_pin   = pin_r;
  assign out_dur   = dur_r;
  assign out_kind  = kind_r;
  assign out_bit   = bit_r;
  assign out_last  = last_r;

endmodule

// File: rtl/vpw_frame_encoder_core.sv
// Top level of the J1850 VPW transmit encoder with CRC-8.
//
// Each accepted input word is one message byte and produces a run of 8 to 18
// output words, one pulse each, at one output word per cycle while the sink is
// ready: a start-of-frame pulse ahead of the first byte of a frame, eight bit
// pulses MSB first, and after the byte marked last the eight CRC bit pulses and
// a passive end-of-frame pulse. The frame controller's position counter steps
// through that run; the next byte is accepted in the same cycle that the final
// pulse of the current run enters the output register, so runs follow with no
// gap. Durations are in whole microseconds and already divided by four in 4x
// mode (speed is sampled on the first byte of a frame). Pin levels follow
// active_high, written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block is idle, which the block itself does not enforce.
module vpw_frame_encoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,  // active_high
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] data_byte
  input  logic        in_tlast,     // last_byte
  input  logic        in_tuser,     // speed_4x
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,    // [0] pin_level, [9:1] duration_us, [10] bit_value, zeros
  output logic [1:0]  out_tuser,    // [1:0] symbol_kind
  output logic        out_tlast     // last_of_run
);
  import vfe_pkg::*;

  logic active_high_r;

  sym_req_t         req;
  logic             req_valid;
  logic             req_ready;
  logic             pin;
  logic [DUR_W-1:0] dur;
  sym_kind_t        kind;
  logic             bit_v;

  // The polarity register is the only configuration state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_high_r <= 1'b0;
    end else if (cfg_wr_en) begin
      active_high_r <= cfg_wr_data;
    end
  end

  vfe_frame_ctl u_ctl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_data     (in_tdata),
    .in_last     (in_tlast),
    .in_speed_4x (in_tuser),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req)
  );

  vfe_symbol_gen u_sym (
    .clk         (clk),
    .rst_n       (rst_n),
    .active_high (active_high_r),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_pin     (pin),
    .out_dur     (dur),
    .out_kind    (kind),
    .out_bit     (bit_v),
    .out_last    (out_tlast)
  );

  assign out_tdata = {5'd0, bit_v, dur, pin};
  assign out_tuser = kind;

`ifndef SYNTH
  // A start pulse always has the data bits of its byte behind it.
  a_sof_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == SYM_SOF) |-> !out_tlast)
    else $error("start pulse flagged as last of run");

  // The end pulse closes the run and drives the passive level.
  a_eof_passive_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == SYM_EOF) |-> out_tlast && (out_tdata[0] == !active_high_r))
    else $error("end pulse not last or not passive");

  // Bit pulses only take the short or long length at either speed.
  a_bit_duration: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == SYM_BIT) |->
      (out_tdata[9:1] == 9'd64) || (out_tdata[9:1] == 9'd128) ||
      (out_tdata[9:1] == 9'd16) || (out_tdata[9:1] == 9'd32))
    else $error("bit pulse with illegal duration");

  // A new byte is only taken while the controller is free or closing a run.
  a_accept_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && req_valid |-> req_ready)
    else $error("byte accepted while a run is still stalled");
`endif

endmodule
